// ----- hw/rtl/dcot_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcot_pkg
// Shared types and codes of the drive command and odometry tick block.
// ----------------------------------------------------------------------------
package dcot_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_DECAY_FACTOR  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DISTANCE_GAIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TURN_GAIN     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SILENCE_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BATTERY_LEVEL = 3'd4;

   localparam logic [15:0] RST_DECAY_FACTOR  = 16'd58982;
   localparam logic [23:0] RST_DISTANCE_GAIN = 24'd17157;
   localparam logic [23:0] RST_TURN_GAIN     = 24'd447392;
   localparam logic [15:0] RST_SILENCE_LIMIT = 16'd100;
   localparam logic [6:0]  RST_BATTERY_LEVEL = 7'd100;

   localparam logic [15:0] MODE_IDLE  = 16'd0;
   localparam logic [15:0] MODE_MOVE  = 16'd1;
   localparam logic [15:0] MODE_STOP  = 16'd2;
   localparam logic [15:0] MODE_ESTOP = 16'd3;
   localparam logic [15:0] MODE_RESET = 16'd4;

   localparam logic [2:0] STATUS_IDLE    = 3'd0;
   localparam logic [2:0] STATUS_MOVING  = 3'd1;
   localparam logic [2:0] STATUS_STOPPED = 3'd2;
   localparam logic [2:0] STATUS_ESTOP   = 3'd3;
   localparam logic [2:0] STATUS_ERROR   = 3'd4;

   localparam logic [2:0] FAULT_OK      = 3'd0;
   localparam logic [2:0] FAULT_TIMEOUT = 3'd4;

   localparam logic [11:0] DECIDEG_PER_TURN = 12'd3600;

   typedef struct packed {
      logic [15:0]        mode;
      logic signed [15:0] left_command;
      logic signed [15:0] right_command;
      logic               request_seen;
   } req_type;

   typedef struct packed {
      logic [2:0]         drive_status;
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
      logic signed [15:0] position_x;
      logic signed [15:0] position_y;
      logic [11:0]        heading_decideg;
      logic [6:0]         battery_percent;
      logic [2:0]         fault_code;
   } rsp_type;

   typedef struct packed {
      logic [15:0] decay_factor;
      logic [23:0] distance_gain;
      logic [23:0] turn_gain;
      logic [15:0] silence_limit;
      logic [6:0]  battery_level;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic ramp_l;
      logic ramp_r;
      logic apply;
      logic sum;
      logic mul_d;
      logic mul_t;
      logic mul_x;
      logic mul_y;
      logic update;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

// ----- hw/rtl/dcot_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcot_req_if
// Tick input channel.
// ----------------------------------------------------------------------------
interface dcot_req_if;
   logic             valid;
   logic             ready;
   dcot_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/dcot_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcot_rsp_if
// Tick result channel.
// ----------------------------------------------------------------------------
interface dcot_rsp_if;
   logic             valid;
   logic             ready;
   dcot_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/dcot_csr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcot_csr_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface dcot_csr_if;
   logic                                valid;
   logic                                ready;
   logic [dcot_pkg::CSR_INDEX_W-1:0]    index;
   logic [dcot_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/dcot_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcot_csr
// Configuration registers with their reset values.
// ----------------------------------------------------------------------------
module dcot_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dcot_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dcot_pkg::CSR_DATA_W-1:0]  csr_data,
   output dcot_pkg::cfg_type                cfg
);
   import dcot_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decay_factor  <= RST_DECAY_FACTOR;
         cfg_ff.distance_gain <= RST_DISTANCE_GAIN;
         cfg_ff.turn_gain     <= RST_TURN_GAIN;
         cfg_ff.silence_limit <= RST_SILENCE_LIMIT;
         cfg_ff.battery_level <= RST_BATTERY_LEVEL;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_DECAY_FACTOR:  cfg_ff.decay_factor  <= csr_data[15:0];
            REG_DISTANCE_GAIN: cfg_ff.distance_gain <= csr_data;
            REG_TURN_GAIN:     cfg_ff.turn_gain     <= csr_data;
            REG_SILENCE_LIMIT: cfg_ff.silence_limit <= csr_data[15:0];
            REG_BATTERY_LEVEL: cfg_ff.battery_level <= csr_data[6:0];
            default: ;
         endcase
      end
   end
endmodule

// ----- hw/rtl/dcot_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcot_ctrl
// Sequencer that steps the datapath through one tick.
// ----------------------------------------------------------------------------
module dcot_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dcot_pkg::stat_type stat,
   output dcot_pkg::cmd_type  cmd
);
   import dcot_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RAMP_L = 4'd1;
   localparam logic [3:0] ST_RAMP_R = 4'd2;
   localparam logic [3:0] ST_APPLY  = 4'd3;
   localparam logic [3:0] ST_SUM    = 4'd4;
   localparam logic [3:0] ST_MUL_D  = 4'd5;
   localparam logic [3:0] ST_MUL_T  = 4'd6;
   localparam logic [3:0] ST_MUL_X  = 4'd7;
   localparam logic [3:0] ST_MUL_Y  = 4'd8;
   localparam logic [3:0] ST_UPDATE = 4'd9;
   localparam logic [3:0] ST_DONE   = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RAMP_L;
            end
         end
         ST_RAMP_L: begin
            cmd.ramp_l = 1'b1;
            state_in   = ST_RAMP_R;
         end
         ST_RAMP_R: begin
            cmd.ramp_r = 1'b1;
            state_in   = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_d = 1'b1;
            state_in  = ST_MUL_T;
         end
         ST_MUL_T: begin
            cmd.mul_t = 1'b1;
            state_in  = ST_MUL_X;
         end
         ST_MUL_X: begin
            cmd.mul_x = 1'b1;
            state_in  = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cmd.mul_y = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- hw/rtl/dcot_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcot_datapath
// Speed ramp, odometry arithmetic, sine ROM, watchdog and result register.
// ----------------------------------------------------------------------------
module dcot_datapath #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int POSITION_WIDTH   = 48,
   parameter int SPEED_FRAC_BITS  = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  dcot_pkg::cmd_type  cmd,
   output dcot_pkg::stat_type stat,
   input  dcot_pkg::req_type  req_data,
   input  dcot_pkg::cfg_type  cfg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dcot_pkg::rsp_type  rsp_data
);
   import dcot_pkg::*;

   localparam int FB = SPEED_FRAC_BITS;
   localparam int SW = 17 + FB;
   localparam int PW = POSITION_WIDTH;
   localparam int AW = $clog2(SINE_TABLE_DEPTH);
   localparam int DW = SW + 24 - FB;
   localparam int XW = (PW > DW + 1) ? PW : DW + 1;
   localparam logic [SW-1:0] SPEED_ONE = {{(SW-1){1'b0}}, 1'b1} << FB;
   localparam logic [63:0]   PI_Q30    = 64'd3373259426;

   typedef logic signed [15:0] rom_type [SINE_TABLE_DEPTH];

   function automatic logic signed [15:0] sine_q15(logic [31:0] a);
      logic [1:0]         q;
      logic [63:0]        r;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] s;
      int                 n;
      q = a[31:30];
      r = {34'd0, a[29:0]};
      if (q[0]) r = 64'h4000_0000 - r;
      x    = (r * PI_Q30) >> 31;
      x2   = (x * x) >> 30;
      term = x;
      s    = $signed(x);
      for (n = 1; n <= 6; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n[0]) s = s - $signed(term);
         else s = s + $signed(term);
      end
      if (s < 0) s = 0;
      s = (s + 64'sd16384) >>> 15;
      if (s > 64'sd32767) s = 64'sd32767;
      return q[1] ? 16'(-s) : 16'(s);
   endfunction

   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] ang;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         ang    = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
         rom[k] = sine_q15(ang[31:0]);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   function automatic logic [AW-1:0] angle_index(logic [31:0] a);
      logic [32+AW:0] p;
      p = (33 + AW)'(a) * (33 + AW)'(SINE_TABLE_DEPTH);
      return p[32 +: AW];
   endfunction

   function automatic logic is_slow(logic signed [SW-1:0] v);
      return (v < $signed(SPEED_ONE)) && (v > -$signed(SPEED_ONE));
   endfunction

   function automatic logic [15:0] clamp16(logic neg, logic [PW:0] m);
      logic [PW:0] t;
      t = -m;
      if (neg) begin
         if (m > (PW + 1)'(32768)) return 16'h8000;
         return t[15:0];
      end
      if (m > (PW + 1)'(32767)) return 16'h7FFF;
      return m[15:0];
   endfunction

   // tick state
   logic [15:0]          mode_ff;
   logic signed [15:0]   lcmd_ff, rcmd_ff;
   logic [15:0]          silence_ff;
   logic signed [SW-1:0] left_ff, right_ff;
   logic signed [SW-1:0] ramp_l_ff, ramp_r_ff;
   logic signed [PW-1:0] x_ff, y_ff;
   logic [31:0]          head_ff;
   logic [2:0]           status_ff, fault_ff;
   logic signed [15:0]   sin_ff, cos_ff;
   logic [SW:0]          sum_mag_ff, diff_mag_ff;
   logic                 sum_neg_ff, diff_neg_ff;
   logic [DW-1:0]        d_mag_ff, dx_mag_ff, dy_mag_ff;
   logic                 dx_neg_ff, dy_neg_ff;
   logic [31:0]          turn_mag_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   // ramp
   logic signed [SW-1:0] ramp_src;
   logic [SW-1:0]        ramp_mag;
   logic [SW+15:0]       ramp_prod;
   logic signed [SW-1:0] ramp_shr;
   logic signed [SW-1:0] ramp_in;

   assign ramp_src  = cmd.ramp_r ? right_ff : left_ff;
   assign ramp_mag  = ramp_src[SW-1] ? SW'(-ramp_src) : SW'(ramp_src);
   assign ramp_prod = (SW + 16)'(ramp_mag) * (SW + 16)'(cfg.decay_factor);
   assign ramp_shr  = $signed(ramp_prod[SW+15:16]);
   assign ramp_in   = (ramp_mag < SPEED_ONE) ? '0 :
                      (ramp_src[SW-1] ? -ramp_shr : ramp_shr);

   // sums and rom addresses
   logic signed [SW:0] lr_sum, lr_diff;
   logic [AW-1:0]      sin_addr, cos_addr;

   assign lr_sum   = (SW + 1)'(left_ff) + (SW + 1)'(right_ff);
   assign lr_diff  = (SW + 1)'(right_ff) - (SW + 1)'(left_ff);
   assign sin_addr = angle_index(head_ff);
   assign cos_addr = angle_index(head_ff + 32'h4000_0000);

   // products
   logic [SW+24:0]     d_prod, t_prod;
   logic signed [15:0] trig_sel;
   logic [15:0]        trig_mag;
   logic [DW+15:0]     p_prod;

   assign d_prod   = (SW + 25)'(sum_mag_ff) * (SW + 25)'(cfg.distance_gain);
   assign t_prod   = (SW + 25)'(diff_mag_ff) * (SW + 25)'(cfg.turn_gain);
   assign trig_sel = cmd.mul_y ? sin_ff : cos_ff;
   assign trig_mag = trig_sel[15] ? 16'(-trig_sel) : 16'(trig_sel);
   assign p_prod   = (DW + 16)'(d_mag_ff) * (DW + 16)'(trig_mag);

   // position update
   logic [XW-1:0] x_sum, y_sum;
   logic          moving;
   logic          watchdog;

   assign x_sum = dx_neg_ff ? (XW'(x_ff) - XW'(dx_mag_ff)) : (XW'(x_ff) + XW'(dx_mag_ff));
   assign y_sum = dy_neg_ff ? (XW'(y_ff) - XW'(dy_mag_ff)) : (XW'(y_ff) + XW'(dy_mag_ff));
   assign moving   = (left_ff != '0) || (right_ff != '0);
   assign watchdog = (silence_ff >= cfg.silence_limit) && (status_ff != STATUS_ESTOP);

   // result fields
   logic [SW-1:0] lmag, rmag;
   logic [PW:0]   xmag, ymag;
   logic [43:0]   h_prod;

   assign lmag   = left_ff[SW-1] ? SW'(-left_ff) : SW'(left_ff);
   assign rmag   = right_ff[SW-1] ? SW'(-right_ff) : SW'(right_ff);
   assign xmag   = x_ff[PW-1] ? -(PW + 1)'(x_ff) : (PW + 1)'(x_ff);
   assign ymag   = y_ff[PW-1] ? -(PW + 1)'(y_ff) : (PW + 1)'(y_ff);
   assign h_prod = 44'(head_ff) * 44'(DECIDEG_PER_TURN);

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_data.mode;
         lcmd_ff <= req_data.left_command;
         rcmd_ff <= req_data.right_command;
      end
      if (cmd.ramp_l) ramp_l_ff <= ramp_in;
      if (cmd.ramp_r) ramp_r_ff <= ramp_in;
      if (cmd.sum) begin
         sum_neg_ff  <= lr_sum[SW];
         sum_mag_ff  <= lr_sum[SW] ? (SW + 1)'(-lr_sum) : (SW + 1)'(lr_sum);
         diff_neg_ff <= lr_diff[SW];
         diff_mag_ff <= lr_diff[SW] ? (SW + 1)'(-lr_diff) : (SW + 1)'(lr_diff);
         sin_ff      <= SINE_ROM[sin_addr];
         cos_ff      <= SINE_ROM[cos_addr];
      end
      if (cmd.mul_d) d_mag_ff <= d_prod[SW+24:FB+1];
      if (cmd.mul_t) turn_mag_ff <= t_prod[FB +: 32];
      if (cmd.mul_x) begin
         dx_mag_ff <= p_prod[DW+14:15];
         dx_neg_ff <= sum_neg_ff ^ cos_ff[15];
      end
      if (cmd.mul_y) begin
         dy_mag_ff <= p_prod[DW+14:15];
         dy_neg_ff <= sum_neg_ff ^ sin_ff[15];
      end
      if (cmd.emit) begin
         rsp_data_ff.drive_status    <= status_ff;
         rsp_data_ff.left_speed      <= clamp16(left_ff[SW-1], (PW + 1)'(lmag >> FB));
         rsp_data_ff.right_speed     <= clamp16(right_ff[SW-1], (PW + 1)'(rmag >> FB));
         rsp_data_ff.position_x      <= clamp16(x_ff[PW-1], xmag >> 16);
         rsp_data_ff.position_y      <= clamp16(y_ff[PW-1], ymag >> 16);
         rsp_data_ff.heading_decideg <= h_prod[43:32];
         rsp_data_ff.battery_percent <= cfg.battery_level;
         rsp_data_ff.fault_code      <= fault_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         silence_ff   <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         head_ff      <= '0;
         status_ff    <= STATUS_IDLE;
         fault_ff     <= FAULT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            if (req_data.request_seen) silence_ff <= '0;
            else if (silence_ff != 16'hFFFF) silence_ff <= silence_ff + 16'd1;
         end
         if (cmd.apply) begin
            unique case (mode_ff)
               MODE_MOVE: begin
                  if (status_ff != STATUS_ESTOP && status_ff != STATUS_ERROR) begin
                     left_ff   <= SW'(lcmd_ff) <<< FB;
                     right_ff  <= SW'(rcmd_ff) <<< FB;
                     status_ff <= STATUS_MOVING;
                  end
               end
               MODE_STOP: begin
                  if (is_slow(ramp_l_ff) && is_slow(ramp_r_ff)) begin
                     left_ff   <= '0;
                     right_ff  <= '0;
                     status_ff <= STATUS_STOPPED;
                  end else begin
                     left_ff   <= ramp_l_ff;
                     right_ff  <= ramp_r_ff;
                     status_ff <= STATUS_MOVING;
                  end
               end
               MODE_ESTOP: begin
                  left_ff   <= '0;
                  right_ff  <= '0;
                  status_ff <= STATUS_ESTOP;
               end
               MODE_RESET: begin
                  left_ff   <= '0;
                  right_ff  <= '0;
                  status_ff <= STATUS_IDLE;
                  fault_ff  <= FAULT_OK;
               end
               default: begin
                  if (status_ff == STATUS_MOVING) begin
                     if (is_slow(ramp_l_ff) && is_slow(ramp_r_ff)) begin
                        left_ff   <= '0;
                        right_ff  <= '0;
                        status_ff <= STATUS_IDLE;
                     end else begin
                        left_ff  <= ramp_l_ff;
                        right_ff <= ramp_r_ff;
                     end
                  end
               end
            endcase
         end
         if (cmd.update) begin
            if (moving) begin
               x_ff    <= $signed(x_sum[PW-1:0]);
               y_ff    <= $signed(y_sum[PW-1:0]);
               head_ff <= diff_neg_ff ? (head_ff - turn_mag_ff) : (head_ff + turn_mag_ff);
            end
            if (watchdog) begin
               left_ff   <= '0;
               right_ff  <= '0;
               status_ff <= STATUS_ESTOP;
               fault_ff  <= FAULT_TIMEOUT;
            end
         end
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end
endmodule

// ----- hw/rtl/drive_command_odometry_tick_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_command_odometry_tick_top
// Per-tick drive command handling with differential-drive odometry.
// ----------------------------------------------------------------------------
// One tick item is accepted, then the block works on it until its result
// enters the output register; the next tick is accepted in the cycle after
// that, so a new tick is not taken before the last one is through. The work
// is the step sequence of the datapath: two speed ramp multiplies, the mode
// decision, the sine ROM read with the wheel sums, the travel and turn
// multiplies, the x and y projections, the state update and the output
// register load. A result left waiting in the output register holds the
// block only when the following tick is finished too. Configuration writes
// are taken at any time, one per cycle.
module drive_command_odometry_tick_top #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int POSITION_WIDTH   = 48,
   parameter int SPEED_FRAC_BITS  = 8
) (
   input logic      clock,
   input logic      reset,
   dcot_req_if.sink req_ch,
   dcot_rsp_if.source rsp_ch,
   dcot_csr_if.sink csr_ch
);
   import dcot_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   dcot_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .cfg       (cfg)
   );

   dcot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dcot_datapath #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .POSITION_WIDTH   (POSITION_WIDTH),
      .SPEED_FRAC_BITS  (SPEED_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_ch.data),
      .cfg       (cfg),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_data  (rsp_ch.data)
   );
endmodule

// ----- hw/rtl/dcot_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcot_checker
// Port-level checks of the drive command and odometry tick block.
// ----------------------------------------------------------------------------
module dcot_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dcot_pkg::rsp_type rsp_data
);
   import dcot_pkg::*;

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

   // heading stays below one turn
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.heading_decideg < DECIDEG_PER_TURN)
      else $error("heading out of range");

   // wheels stand still unless moving
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.drive_status != STATUS_MOVING |->
         rsp_data.left_speed == 16'sd0 && rsp_data.right_speed == 16'sd0)
      else $error("speed nonzero while not moving");

   // only timeout fault is raised
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.fault_code == FAULT_OK || rsp_data.fault_code == FAULT_TIMEOUT)
      else $error("unexpected fault code");
endmodule

bind drive_command_odometry_tick_top dcot_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

// ----- bench/tb_drive_command_odometry_tick_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drive_command_odometry_tick_top
// Drive command and odometry tick block: directed and random ticks go through
// a queue-fed driver. A local predictor keeps the speed, odometry and watchdog
// state and checks every result field by field, with random stalls on both
// channels and several register settings written while the block is idle.
// ----------------------------------------------------------------------------
module tb_drive_command_odometry_tick_top;
   import dcot_pkg::*;

   localparam int TABLE_DEPTH = 1024;
   localparam int FRAC        = 8;
   localparam longint ONE_RPM = 64'sd1 << FRAC;
   localparam longint PI_Q30  = 64'd3373259426;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dcot_req_if req_ch ();
   dcot_rsp_if rsp_ch ();
   dcot_csr_if csr_ch ();

   drive_command_odometry_tick_top dut (
      .clock(clock), .reset(reset),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source), .csr_ch(csr_ch.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [15:0] sine_rom [TABLE_DEPTH];
   logic [15:0] decay_factor;
   logic [23:0] distance_gain;
   logic [23:0] turn_gain;
   logic [15:0] silence_limit;
   logic [6:0]  battery_level;
   longint left_actual, right_actual, x_accum, y_accum;
   logic [31:0] heading_angle;
   logic [2:0]  status_reg, fault_reg;
   logic [15:0] silence_count;

   req_type tick_queue [$];
   rsp_type expected_odometry [$];
   int errors = 0;
   int hold_off = 0;
   int stall = 0;

   function automatic longint shift_toward_zero(longint v, int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = m >>> s;
      return (v < 0) ? -m : m;
   endfunction

   function automatic logic signed [15:0] sine_value(logic [31:0] a);
      logic [1:0] q;
      longint unsigned r, x, x2, term;
      longint s;
      q = a[31:30];
      r = {34'd0, a[29:0]};
      if (q[0]) r = 64'h4000_0000 - r;
      x = (r * PI_Q30) >> 31;
      x2 = (x * x) >> 30;
      term = x;
      s = x;
      for (int n = 1; n <= 6; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) s = s - longint'(term);
         else s = s + longint'(term);
      end
      if (s < 0) s = 0;
      s = (s + 16384) >>> 15;
      if (s > 32767) s = 32767;
      return (q >= 2) ? 16'(-s) : 16'(s);
   endfunction

   function automatic longint rom_lookup(logic [31:0] a);
      longint unsigned idx;
      idx = (longint'(a) * TABLE_DEPTH) >> 32;
      return longint'(sine_rom[idx]);
   endfunction

   function automatic longint ramp_speed(longint s);
      if (s < ONE_RPM && s > -ONE_RPM) return 0;
      return shift_toward_zero(s * longint'(decay_factor), 16);
   endfunction

   function automatic bit speeds_below_one();
      return left_actual < ONE_RPM && left_actual > -ONE_RPM &&
             right_actual < ONE_RPM && right_actual > -ONE_RPM;
   endfunction

   function automatic longint wrap_position(longint v);
      return longint'({{16{v[47]}}, v[47:0]});
   endfunction

   function automatic logic [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic void predictor_reset();
      for (int k = 0; k < TABLE_DEPTH; k++)
         sine_rom[k] = sine_value(32'((longint'(k) << 32) / TABLE_DEPTH));
      decay_factor = RST_DECAY_FACTOR;
      distance_gain = RST_DISTANCE_GAIN;
      turn_gain = RST_TURN_GAIN;
      silence_limit = RST_SILENCE_LIMIT;
      battery_level = RST_BATTERY_LEVEL;
      left_actual = 0; right_actual = 0; x_accum = 0; y_accum = 0;
      heading_angle = 0; status_reg = STATUS_IDLE; fault_reg = FAULT_OK;
      silence_count = 0;
   endfunction

   function automatic void register_update(logic [2:0] index, logic [23:0] value);
      case (index)
         REG_DECAY_FACTOR: decay_factor = value[15:0];
         REG_DISTANCE_GAIN: distance_gain = value;
         REG_TURN_GAIN: turn_gain = value;
         REG_SILENCE_LIMIT: silence_limit = value[15:0];
         REG_BATTERY_LEVEL: battery_level = value[6:0];
         default: ;
      endcase
   endfunction

   function automatic rsp_type odometry_step(req_type t);
      rsp_type r;
      longint d, c, s, turn;
      if (t.request_seen) silence_count = 0;
      else if (silence_count != 16'hffff) silence_count++;
      case (t.mode)
         MODE_MOVE: begin
            if (status_reg != STATUS_ESTOP && status_reg != STATUS_ERROR) begin
               left_actual = longint'(t.left_command) * ONE_RPM;
               right_actual = longint'(t.right_command) * ONE_RPM;
               status_reg = STATUS_MOVING;
            end
         end
         MODE_STOP: begin
            left_actual = ramp_speed(left_actual);
            right_actual = ramp_speed(right_actual);
            if (speeds_below_one()) begin
               left_actual = 0; right_actual = 0; status_reg = STATUS_STOPPED;
            end else status_reg = STATUS_MOVING;
         end
         MODE_ESTOP: begin
            left_actual = 0; right_actual = 0; status_reg = STATUS_ESTOP;
         end
         MODE_RESET: begin
            fault_reg = FAULT_OK; status_reg = STATUS_IDLE;
            left_actual = 0; right_actual = 0;
         end
         default: begin
            if (status_reg == STATUS_MOVING) begin
               left_actual = ramp_speed(left_actual);
               right_actual = ramp_speed(right_actual);
               if (speeds_below_one()) begin
                  left_actual = 0; right_actual = 0; status_reg = STATUS_IDLE;
               end
            end
         end
      endcase
      if (left_actual != 0 || right_actual != 0) begin
         d = shift_toward_zero((left_actual + right_actual) * longint'(distance_gain),
            FRAC + 1);
         c = rom_lookup(heading_angle + 32'h4000_0000);
         s = rom_lookup(heading_angle);
         turn = shift_toward_zero((right_actual - left_actual) * longint'(turn_gain), FRAC);
         x_accum = wrap_position(x_accum + shift_toward_zero(d * c, 15));
         y_accum = wrap_position(y_accum + shift_toward_zero(d * s, 15));
         heading_angle = heading_angle + turn[31:0];
      end
      if (silence_count >= silence_limit && status_reg != STATUS_ESTOP) begin
         left_actual = 0; right_actual = 0;
         status_reg = STATUS_ESTOP; fault_reg = FAULT_TIMEOUT;
      end
      r.drive_status = status_reg;
      r.left_speed = clamp16(shift_toward_zero(left_actual, FRAC));
      r.right_speed = clamp16(shift_toward_zero(right_actual, FRAC));
      r.position_x = clamp16(shift_toward_zero(x_accum, 16));
      r.position_y = clamp16(shift_toward_zero(y_accum, 16));
      r.heading_decideg = 12'((longint'(heading_angle) * DECIDEG_PER_TURN) >> 32);
      r.battery_percent = battery_level;
      r.fault_code = fault_reg;
      return r;
   endfunction

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         hold_off <= 0;
      end else if (req_ch.valid && !req_ch.ready) begin
      end else if (hold_off > 0) begin
         req_ch.valid <= 1'b0;
         hold_off <= hold_off - 1;
      end else if (tick_queue.size() > 0) begin
         req_ch.valid <= 1'b1;
         req_ch.data <= tick_queue.pop_front();
         hold_off <= gap_length();
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         expected_odometry.push_back(odometry_step(req_ch.data));
   end

   // monitor
   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_odometry.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_ch.data);
               errors++;
            end else begin
               exp_r = expected_odometry.pop_front();
               if (rsp_ch.data.drive_status !== exp_r.drive_status ||
                   rsp_ch.data.left_speed !== exp_r.left_speed ||
                   rsp_ch.data.right_speed !== exp_r.right_speed ||
                   rsp_ch.data.position_x !== exp_r.position_x ||
                   rsp_ch.data.position_y !== exp_r.position_y ||
                   rsp_ch.data.heading_decideg !== exp_r.heading_decideg ||
                   rsp_ch.data.battery_percent !== exp_r.battery_percent ||
                   rsp_ch.data.fault_code !== exp_r.fault_code) begin
                  $display("%0t: mismatch expected %p actual %p", $time, exp_r,
                     rsp_ch.data);
                  errors++;
               end
            end
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall <= stall - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall <= gap_length();
         end
      end
   end

   task automatic write_register(logic [2:0] index, logic [23:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      register_update(index, value);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (tick_queue.size() > 0 || req_ch.valid || expected_odometry.size() > 0)
         @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic void add_tick(logic [15:0] mode, logic [15:0] l, logic [15:0] r,
      logic req);
      req_type t;
      t.mode = mode; t.left_command = l; t.right_command = r; t.request_seen = req;
      tick_queue.push_back(t);
   endfunction

   function automatic logic [15:0] random_speed();
      int p;
      p = $urandom_range(0, 9);
      if (p < 6) return 16'($signed($urandom_range(0, 400)) - 200);
      if (p < 8) return 16'($signed($urandom_range(0, 6000)) - 3000);
      return 16'($urandom);
   endfunction

   function automatic void random_motion(int count);
      logic [15:0] mode;
      int p;
      for (int i = 0; i < count; i++) begin
         p = $urandom_range(0, 99);
         if (p < 40) mode = MODE_MOVE;
         else if (p < 60) mode = MODE_STOP;
         else if (p < 75) mode = MODE_IDLE;
         else if (p < 82) mode = MODE_ESTOP;
         else if (p < 92) mode = MODE_RESET;
         else mode = 16'($urandom_range(5, 65535));
         add_tick(mode, random_speed(), random_speed(), $urandom_range(0, 9) != 0);
      end
   endfunction

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      predictor_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every mode, field extremes, ramp-down and unknown mode
      add_tick(MODE_MOVE, 16'sh7fff, 16'sh8000, 1'b1);
      add_tick(MODE_MOVE, 16'sh8000, 16'sh7fff, 1'b1);
      add_tick(MODE_MOVE, 16'sd100, 16'sd120, 1'b1);
      add_tick(MODE_IDLE, 16'hffff, 16'h0000, 1'b1);
      add_tick(MODE_STOP, 16'h0, 16'h0, 1'b1);
      repeat (6) add_tick(MODE_STOP, 16'h0, 16'h0, 1'b1);
      add_tick(MODE_ESTOP, 16'h0, 16'h0, 1'b1);
      add_tick(MODE_MOVE, 16'sd50, 16'sd50, 1'b1);
      add_tick(MODE_STOP, 16'h0, 16'h0, 1'b1);
      add_tick(MODE_RESET, 16'h0, 16'h0, 1'b1);
      add_tick(16'hffff, 16'h5555, 16'haaaa, 1'b1);
      add_tick(MODE_MOVE, 16'sd3, 16'sd2, 1'b1);
      repeat (30) add_tick(MODE_IDLE, 16'h0, 16'h0, 1'b1);
      wait_idle();

      // watchdog with a short limit, small decay and the reset gains
      write_register(REG_SILENCE_LIMIT, 24'd1);
      write_register(REG_DECAY_FACTOR, 24'd0);
      write_register(REG_BATTERY_LEVEL, 24'd0);
      add_tick(MODE_MOVE, 16'sd10, 16'sd20, 1'b0);
      add_tick(MODE_RESET, 16'sd0, 16'sd0, 1'b1);
      add_tick(MODE_MOVE, 16'sd10, 16'sd20, 1'b1);
      add_tick(MODE_STOP, 16'sd0, 16'sd0, 1'b1);
      wait_idle();

      write_register(REG_SILENCE_LIMIT, 24'd65535);
      write_register(REG_DECAY_FACTOR, 24'd65535);
      write_register(REG_DISTANCE_GAIN, 24'hffffff);
      write_register(REG_TURN_GAIN, 24'hffffff);
      write_register(REG_BATTERY_LEVEL, 24'd100);
      random_motion(120);
      wait_idle();

      write_register(REG_DECAY_FACTOR, RST_DECAY_FACTOR);
      write_register(REG_DISTANCE_GAIN, 24'd0);
      write_register(REG_TURN_GAIN, 24'd0);
      write_register(REG_SILENCE_LIMIT, 24'd8);
      write_register(REG_BATTERY_LEVEL, 24'd57);
      random_motion(110);
      wait_idle();

      write_register(REG_DECAY_FACTOR, 24'($urandom_range(30000, 65535)));
      write_register(REG_DISTANCE_GAIN, 24'($urandom_range(1, 200000)));
      write_register(REG_TURN_GAIN, 24'($urandom_range(1, 4000000)));
      write_register(REG_SILENCE_LIMIT, 24'd40);
      write_register(REG_BATTERY_LEVEL, 24'd100);
      random_motion(200);
      wait_idle();

      if (errors == 0) begin
         $display("PASS drive_command_odometry_tick_top");
      end else begin
         $display("FAIL drive_command_odometry_tick_top");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL drive_command_odometry_tick_top");
      $finish;
   end

endmodule

// ----- drive_command_odometry_tick_top.f -----
hw/rtl/dcot_pkg.sv
hw/rtl/dcot_req_if.sv
hw/rtl/dcot_rsp_if.sv
hw/rtl/dcot_csr_if.sv
hw/rtl/dcot_csr.sv
hw/rtl/dcot_ctrl.sv
hw/rtl/dcot_datapath.sv
hw/rtl/drive_command_odometry_tick_top.sv
hw/rtl/dcot_checker.sv
bench/tb_drive_command_odometry_tick_top.sv
